@@ sv/lsf_pkg.sv @@
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared constants for the largest square finder: port widths, register
// indexes and field layout of the result word.
// ----------------------------------------------------------------------------
package lsf_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd1;

  localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RESET = 11'd1024;

  // stream widths
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 32;

  // result fields, lowest bit first
  localparam int SIDE_W = 11;
  localparam int ROW_W  = 10;
  localparam int COL_W  = 10;

endpackage

@@ sv/largest_square_finder.sv @@
// ----------------------------------------------------------------------------
// largest_square_finder
// Maximal all-set square search over a binary grid streamed in raster order.
// ----------------------------------------------------------------------------
// The block takes one grid cell per clock transfer on the slave stream, row by
// row and left to right, with grid_cols and grid_rows set beforehand on the
// configuration channel (0 acts as 1, values above MAX_COLS / MAX_ROWS
// saturate). A grid of any size streams at one cell per cycle while the result
// registers have room: each cell reads the score of the cell above from the
// line store memory through a registered read and writes its score back from
// stage 1, so the memory port pair sets the rate. On a one-column grid the
// cell above is written in the same cycle and forwarded around the memory.
// Results pass through an output register with a second register behind it, so
// the last cell of a grid is held back only when both would still be full as
// its result lands, that is while the master stream stalls with two results
// waiting; with the master stream keeping up, grids follow each other with no
// lost cycle, down to one-cell grids. One result transfer follows the last
// cell of each grid, through the stage 1 and output registers: the side of
// the first largest square found in raster order and its top-left row and
// column, all zero when no cell was set. The line store needs no clearing after
// reset: the first row of a grid ignores what it reads. Configuration writes
// are always taken and belong between grids only.
// ----------------------------------------------------------------------------
module largest_square_finder #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lsf_pkg::CFG_DATA_W-1:0]  cfg_data_i,

  // cell stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lsf_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [0] cell_is_set, rest zero

  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lsf_pkg::M_TDATA_W-1:0]   m_axis_tdata    // [10:0] square_side,
                                                          // [20:11] square_top_row,
                                                          // [30:21] square_left_col,
                                                          // [31] zero
);

  localparam int CW     = $clog2(MAX_COLS);
  localparam int RW     = $clog2(MAX_ROWS);
  localparam int MIN_SZ = (MAX_COLS < MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int SW     = $clog2(MIN_SZ + 1);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [lsf_pkg::CFG_DATA_W-1:0] grid_cols_q, grid_rows_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= lsf_pkg::GRID_SIZE_RESET;
      grid_rows_q <= lsf_pkg::GRID_SIZE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lsf_pkg::REG_GRID_COLS: grid_cols_q <= cfg_data_i;
        lsf_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_data_i;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // effective sizes: zero acts as one, large values saturate
  logic [31:0] cols_eff, rows_eff;

  always_comb begin
    if (grid_cols_q == '0) begin
      cols_eff = 32'd1;
    end else if (32'(grid_cols_q) > 32'(MAX_COLS)) begin
      cols_eff = 32'(MAX_COLS);
    end else begin
      cols_eff = 32'(grid_cols_q);
    end
    if (grid_rows_q == '0) begin
      rows_eff = 32'd1;
    end else if (32'(grid_rows_q) > 32'(MAX_ROWS)) begin
      rows_eff = 32'(MAX_ROWS);
    end else begin
      rows_eff = 32'(grid_rows_q);
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: position counters and line store read
  // --------------------------------------------------------------------------
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          row_end, grid_end, in_xfer;

  assign row_end  = (32'(col_q) + 32'd1) >= cols_eff;
  assign grid_end = row_end && ((32'(row_q) + 32'd1) >= rows_eff);

  // stage 1 and result state, declared here for the ready term
  logic          s1_valid_q, s1_last_q, s1_set_q, s1_first_row_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic          out_valid_q, skid_valid_q, res_load;

  assign res_load = s1_valid_q && s1_last_q;

  // the last cell of a grid needs a free result slot when it lands
  assign s_axis_tready = !(grid_end && out_valid_q && !m_axis_tready &&
                           (skid_valid_q || res_load));
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_xfer) begin
      if (!row_end) begin
        col_q <= col_q + CW'(1);
      end else begin
        col_q <= '0;
        row_q <= grid_end ? '0 : row_q + RW'(1);
      end
    end
  end

  // line store: previous row scores, one entry per column
  logic [SW-1:0] line_mem [MAX_COLS];
  logic [SW-1:0] rd_data_q;
  logic          fwd_q;
  logic [SW-1:0] fwd_data_q;
  logic [SW-1:0] side_v;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      line_mem[s1_col_q] <= side_v;
    end
    if (in_xfer) begin
      rd_data_q <= line_mem[col_q];
    end
  end

  // same entry read while being written: hand the new score around the memory
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      fwd_data_q <= side_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_xfer) begin
      fwd_q <= s1_valid_q && (s1_col_q == col_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_xfer;
      s1_last_q  <= in_xfer && grid_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_set_q       <= s_axis_tdata[0];
      s1_col_q       <= col_q;
      s1_row_q       <= row_q;
      s1_first_row_q <= (row_q == '0);
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: score, best tracking, line store write back
  // --------------------------------------------------------------------------
  logic [SW-1:0] left_q, upper_left_q;
  logic [SW-1:0] stored, up_v, left_v, ul_v, min_ul, min_all;

  always_comb begin
    stored  = fwd_q ? fwd_data_q : rd_data_q;
    up_v    = s1_first_row_q ? '0 : stored;
    left_v  = (s1_col_q == '0) ? '0 : left_q;
    ul_v    = (s1_first_row_q || (s1_col_q == '0)) ? '0 : upper_left_q;
    min_ul  = (up_v < left_v) ? up_v : left_v;
    min_all = (min_ul < ul_v) ? min_ul : ul_v;
    side_v  = s1_set_q ? min_all + SW'(1) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      left_q       <= side_v;
      upper_left_q <= stored;
    end
  end

  logic [SW-1:0] best_side_q, best_side_n;
  logic [RW-1:0] best_row_q, best_row_n;
  logic [CW-1:0] best_col_q, best_col_n;
  logic          better;

  // only a strictly greater score replaces the best, first one wins
  assign better      = s1_valid_q && (side_v > best_side_q);
  assign best_side_n = better ? side_v   : best_side_q;
  assign best_row_n  = better ? s1_row_q : best_row_q;
  assign best_col_n  = better ? s1_col_q : best_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_side_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
    end else if (s1_valid_q) begin
      if (s1_last_q) begin
        best_side_q <= '0;
        best_row_q  <= '0;
        best_col_q  <= '0;
      end else begin
        best_side_q <= best_side_n;
        best_row_q  <= best_row_n;
        best_col_q  <= best_col_n;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result registers: output register with a second one behind it
  // --------------------------------------------------------------------------
  logic [31:0]               top_wide, left_wide;
  logic [lsf_pkg::SIDE_W-1:0] res_side;
  logic [lsf_pkg::ROW_W-1:0]  res_row;
  logic [lsf_pkg::COL_W-1:0]  res_col;
  logic [lsf_pkg::M_TDATA_W-1:0] res_word;
  logic [lsf_pkg::M_TDATA_W-1:0] out_data_q;
  logic [lsf_pkg::M_TDATA_W-1:0] skid_data_q;

  always_comb begin
    top_wide  = 32'(best_row_n) + 32'd1 - 32'(best_side_n);
    left_wide = 32'(best_col_n) + 32'd1 - 32'(best_side_n);
    if (best_side_n == '0) begin
      // empty grid reports all zero
      res_side = '0;
      res_row  = '0;
      res_col  = '0;
    end else begin
      res_side = lsf_pkg::SIDE_W'(best_side_n);
      res_row  = top_wide[lsf_pkg::ROW_W-1:0];
      res_col  = left_wide[lsf_pkg::COL_W-1:0];
    end
  end

  assign res_word = {1'b0, res_col, res_row, res_side};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      // output register frees up: the waiting result moves first, keeping order
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= res_load;
      end else begin
        out_valid_q  <= res_load;
        skid_valid_q <= 1'b0;
      end
    end else if (res_load) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (res_load) begin
        out_data_q <= res_word;
      end
    end
    if (res_load && (skid_valid_q || (out_valid_q && !m_axis_tready))) begin
      skid_data_q <= res_word;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ sv/lsf_checker.sv @@
// ----------------------------------------------------------------------------
// lsf_checker
// Port-level checks of the largest square finder, bound to the top level.
// ----------------------------------------------------------------------------
module lsf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [lsf_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result stays and holds its data
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // a result only follows a cell transfer through stage 1 and the output register
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a preceding cell transfer");

  // handshake outputs never go unknown out of reset
  a_handshake_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({m_axis_tvalid, s_axis_tready}))
    else $error("unknown value on a handshake output");

endmodule

bind largest_square_finder lsf_checker u_lsf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
